@@ design/rfn_pkg.sv @@
`timescale 1ns / 1ps

package rfn_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  // largest magnitude a signed result can carry
  localparam logic [DATA_WIDTH-1:0] MAX_MAG = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  typedef logic [DATA_WIDTH-1:0] mag_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EUC_GO,
    S_EUC_WAIT,
    S_NUM_GO,
    S_NUM_WAIT,
    S_DEN_GO,
    S_DEN_WAIT,
    S_OUT
  } rfn_state_t;

  typedef struct packed {
    logic start;
    mag_t dividend;
    mag_t divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    mag_t quotient;
    mag_t remainder;
  } div_rsp_t;

endpackage

@@ design/rfn_if.sv @@
`timescale 1ns / 1ps

interface rfn_in_if import rfn_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] num_in;
  logic signed [DATA_WIDTH-1:0] den_in;

  modport source (output valid, output num_in, output den_in, input ready);
  modport sink   (input valid, input num_in, input den_in, output ready);
endinterface

interface rfn_out_if import rfn_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] num_out;
  logic        [DATA_WIDTH-2:0] den_out;
  logic                         zero_den_error;

  modport source (output valid, output num_out, output den_out, output zero_den_error,
                  input ready);
  modport sink   (input valid, input num_out, input den_out, input zero_den_error,
                  output ready);
endinterface

@@ design/rational_fraction_normalizer.sv @@
`timescale 1ns / 1ps

// channel   dir  payload                                   handshake
// in_ch     in   num_in[31:0] s, den_in[31:0] s            valid / ready
// out_ch    out  num_out[31:0] s, den_out[30:0], zero_den_error   valid / ready
//
// one request at a time; a single shared restoring divider does every division,
// one quotient bit per cycle; each division runs to done before the next one starts
// a zero denominator goes straight from S_IDLE to S_OUT, past the divider; the result
// is registered in S_OUT once out_ch is free
// reset (rst_n low, synchronous) empties the sequencer, the divider and the result register
// the next request is taken while a finished result waits on out_ch

module rational_fraction_normalizer import rfn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rfn_in_if.sink    in_ch,
  rfn_out_if.source out_ch
);

  rfn_state_t state_r, state_nxt;
  div_req_t   div_req;
  div_rsp_t   div_rsp;

  mag_t nmag_r, nmag_nxt;
  mag_t dmag_r, dmag_nxt;
  mag_t a_r, a_nxt;
  mag_t b_r, b_nxt;
  mag_t rn_r, rn_nxt;
  mag_t rd_r, rd_nxt;
  logic sdiff_r, sdiff_nxt;
  logic err_r, err_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic signed [DATA_WIDTH-1:0] num_out_r, num_out_nxt;
  logic        [DATA_WIDTH-2:0] den_out_r, den_out_nxt;
  logic                         zerr_r, zerr_nxt;

  logic in_req;
  logic out_free;
  mag_t num_raw, den_raw;
  mag_t nmag_in, dmag_in;
  mag_t rn_sat, rd_sat;
  logic neg;

  rfn_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_req      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign num_raw = mag_t'(in_ch.num_in);
  assign den_raw = mag_t'(in_ch.den_in);
  assign nmag_in = num_raw[DATA_WIDTH-1] ? (~num_raw + 1'b1) : num_raw;
  assign dmag_in = den_raw[DATA_WIDTH-1] ? (~den_raw + 1'b1) : den_raw;

  // magnitude of two to the top bit cannot be shown signed
  assign rn_sat = rn_r[DATA_WIDTH-1] ? MAX_MAG : rn_r;
  assign rd_sat = rd_r[DATA_WIDTH-1] ? MAX_MAG : rd_r;
  assign neg    = sdiff_r && (rn_r != '0);

  always_comb begin
    state_nxt     = state_r;
    nmag_nxt      = nmag_r;
    dmag_nxt      = dmag_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    rn_nxt        = rn_r;
    rd_nxt        = rd_r;
    sdiff_nxt     = sdiff_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    num_out_nxt   = num_out_r;
    den_out_nxt   = den_out_r;
    zerr_nxt      = zerr_r;
    div_req       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_req) begin
          nmag_nxt  = nmag_in;
          dmag_nxt  = dmag_in;
          a_nxt     = nmag_in;
          b_nxt     = dmag_in;
          sdiff_nxt = num_raw[DATA_WIDTH-1] != den_raw[DATA_WIDTH-1];
          err_nxt   = (dmag_in == '0);
          state_nxt = (dmag_in == '0) ? S_OUT : S_EUC_GO;
        end
      end
      S_EUC_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = a_r;
        div_req.divisor  = b_r;
        state_nxt        = S_EUC_WAIT;
      end
      S_EUC_WAIT: begin
        if (div_rsp.done) begin
          a_nxt     = b_r;
          b_nxt     = div_rsp.remainder;
          state_nxt = (div_rsp.remainder == '0) ? S_NUM_GO : S_EUC_GO;
        end
      end
      S_NUM_GO: begin
        // a_r now holds the divisor common to both parts
        div_req.start    = 1'b1;
        div_req.dividend = nmag_r;
        div_req.divisor  = a_r;
        state_nxt        = S_NUM_WAIT;
      end
      S_NUM_WAIT: begin
        if (div_rsp.done) begin
          rn_nxt    = div_rsp.quotient;
          state_nxt = S_DEN_GO;
        end
      end
      S_DEN_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = dmag_r;
        div_req.divisor  = a_r;
        state_nxt        = S_DEN_WAIT;
      end
      S_DEN_WAIT: begin
        if (div_rsp.done) begin
          rd_nxt    = div_rsp.quotient;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (err_r) begin
            num_out_nxt = '0;
            den_out_nxt = '0;
            zerr_nxt    = 1'b1;
          end else begin
            num_out_nxt = neg ? $signed(~rn_sat + 1'b1) : $signed(rn_sat);
            den_out_nxt = rd_sat[DATA_WIDTH-2:0];
            zerr_nxt    = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nmag_r    <= nmag_nxt;
    dmag_r    <= dmag_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    rn_r      <= rn_nxt;
    rd_r      <= rd_nxt;
    sdiff_r   <= sdiff_nxt;
    err_r     <= err_nxt;
    num_out_r <= num_out_nxt;
    den_out_r <= den_out_nxt;
    zerr_r    <= zerr_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.num_out        = num_out_r;
  assign out_ch.den_out        = den_out_r;
  assign out_ch.zero_den_error = zerr_r;

`ifndef NO_ASSERTIONS
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_zero_den_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req && in_ch.den_in == '0) |=> state_r == S_OUT)
    else $error("zero denominator did not go straight to the result");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.zero_den_error) |-> (out_ch.num_out == '0 && out_ch.den_out == '0))
    else $error("error result carries non-zero fields");

  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.zero_den_error) |-> out_ch.den_out != '0)
    else $error("reduced denominator is zero");
`endif

endmodule

@@ design/rfn_divider.sv @@
`timescale 1ns / 1ps

module rfn_divider import rfn_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  mag_t                  rem_r, rem_nxt;
  mag_t                  quo_r, quo_nxt;
  mag_t                  dvs_r, dvs_nxt;
  logic [DATA_WIDTH:0]   shifted;
  mag_t                  diff;
  logic                  fits;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  assign shifted = {rem_r, quo_r[DATA_WIDTH-1]};
  assign fits    = shifted >= {1'b0, dvs_r};
  assign diff    = shifted[DATA_WIDTH-1:0] - dvs_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff : shifted[DATA_WIDTH-1:0];
      quo_nxt = {quo_r[DATA_WIDTH-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DATA_WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule
